/* src/cck_pkg.sv */
// Shared constants and helpers for the centered color-key blitter.
// No dependencies; used by every module of the block.
package cck_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned APB_DW  = 64;
  localparam int unsigned APB_AW  = 6;
  localparam int unsigned REG_IW  = 3;

  // register indexes (paddr[5:3])
  localparam logic [REG_IW-1:0] REG_FRAME_BASE    = 3'd0;
  localparam logic [REG_IW-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [REG_IW-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [REG_IW-1:0] REG_LINE_PITCH    = 3'd3;
  localparam logic [REG_IW-1:0] REG_BYTE_ORDER    = 3'd4;
  localparam logic [REG_IW-1:0] REG_IMAGE_WIDTH   = 3'd5;
  localparam logic [REG_IW-1:0] REG_IMAGE_HEIGHT  = 3'd6;

  localparam logic ORDER_BGR = 1'b1;

  // 0xXXRRGGBB -> 0xBBGGRR (RGB memory order) or 0xRRGGBB (BGR memory order)
  function automatic logic [COLOR_W-1:0] pack_colour(input logic [PIX_W-1:0] px,
                                                    input logic order);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    if (order == ORDER_BGR) begin
      return {r, g, b};
    end
    return {b, g, r};
  endfunction

endpackage

/* src/cck_regs.sv */
// APB configuration registers of the blitter.
// Depends on cck_pkg for register indexes and widths.
module cck_regs #(
  parameter int unsigned DIM_BITS = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cck_pkg::APB_AW-1:0]  paddr,
  input  logic [cck_pkg::APB_DW-1:0]  pwdata,
  output logic [cck_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [cck_pkg::ADDR_W-1:0]  frame_base_o,
  output logic [DIM_BITS-1:0]         screen_width_o,
  output logic [DIM_BITS-1:0]         screen_height_o,
  output logic [DIM_BITS-1:0]         line_pitch_o,
  output logic                        byte_order_o,
  output logic [DIM_BITS-1:0]         image_width_o,
  output logic [DIM_BITS-1:0]         image_height_o
);

  logic [cck_pkg::ADDR_W-1:0] frame_base_q;
  logic [DIM_BITS-1:0]        screen_width_q;
  logic [DIM_BITS-1:0]        screen_height_q;
  logic [DIM_BITS-1:0]        line_pitch_q;
  logic                       byte_order_q;
  logic [DIM_BITS-1:0]        image_width_q;
  logic [DIM_BITS-1:0]        image_height_q;
  logic                       wr_en;
  logic [cck_pkg::REG_IW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // 8-byte register spacing, low address bits ignored
  assign reg_idx = paddr[cck_pkg::APB_AW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q    <= '0;
      screen_width_q  <= '0;
      screen_height_q <= '0;
      line_pitch_q    <= '0;
      byte_order_q    <= 1'b0;
      image_width_q   <= '0;
      image_height_q  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        cck_pkg::REG_FRAME_BASE:    frame_base_q    <= pwdata[cck_pkg::ADDR_W-1:0];
        cck_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[DIM_BITS-1:0];
        cck_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[DIM_BITS-1:0];
        cck_pkg::REG_LINE_PITCH:    line_pitch_q    <= pwdata[DIM_BITS-1:0];
        cck_pkg::REG_BYTE_ORDER:    byte_order_q    <= pwdata[0];
        cck_pkg::REG_IMAGE_WIDTH:   image_width_q   <= pwdata[DIM_BITS-1:0];
        cck_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cck_pkg::REG_FRAME_BASE:    prdata = cck_pkg::APB_DW'(frame_base_q);
      cck_pkg::REG_SCREEN_WIDTH:  prdata = cck_pkg::APB_DW'(screen_width_q);
      cck_pkg::REG_SCREEN_HEIGHT: prdata = cck_pkg::APB_DW'(screen_height_q);
      cck_pkg::REG_LINE_PITCH:    prdata = cck_pkg::APB_DW'(line_pitch_q);
      cck_pkg::REG_BYTE_ORDER:    prdata = cck_pkg::APB_DW'(byte_order_q);
      cck_pkg::REG_IMAGE_WIDTH:   prdata = cck_pkg::APB_DW'(image_width_q);
      cck_pkg::REG_IMAGE_HEIGHT:  prdata = cck_pkg::APB_DW'(image_height_q);
      default:                    prdata = '0;
    endcase
  end

  assign frame_base_o    = frame_base_q;
  assign screen_width_o  = screen_width_q;
  assign screen_height_o = screen_height_q;
  assign line_pitch_o    = line_pitch_q;
  assign byte_order_o    = byte_order_q;
  assign image_width_o   = image_width_q;
  assign image_height_o  = image_height_q;

endmodule

/* src/cck_raster.sv */
// Input register and raster column/row counters of the blitter.
// Depends on cck_pkg for the pixel width.
module cck_raster #(
  parameter int unsigned DIM_BITS = 13
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [cck_pkg::PIX_W-1:0] s_axis_tdata,   // [31:0] source_pixel
  input  logic [DIM_BITS-1:0]       image_width_i,
  input  logic [DIM_BITS-1:0]       image_height_i,
  input  logic                      stage_en_i,
  output logic                      pix_valid_o,
  output logic [cck_pkg::PIX_W-1:0] pix_o,
  output logic [DIM_BITS-1:0]       col_o,
  output logic [DIM_BITS-1:0]       row_o
);

  logic                      in_valid_q, in_valid_d;
  logic [cck_pkg::PIX_W-1:0] pix_q;
  logic [DIM_BITS-1:0]       pcol_q, prow_q;
  logic [DIM_BITS-1:0]       col_q, col_d;
  logic [DIM_BITS-1:0]       row_q, row_d;
  logic [DIM_BITS:0]         col_inc, row_inc;
  logic                      accept;

  assign s_axis_tready = !in_valid_q || stage_en_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign col_inc       = {1'b0, col_q} + 1'b1;
  assign row_inc       = {1'b0, row_q} + 1'b1;

  always_comb begin
    in_valid_d = accept ? 1'b1 : (in_valid_q && !stage_en_i);
    col_d      = col_q;
    row_d      = row_q;
    if (accept) begin
      if (image_width_i == '0 || image_height_i == '0) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= {1'b0, image_width_i}) begin
        col_d = '0;
        row_d = (row_inc >= {1'b0, image_height_i}) ? '0 : row_inc[DIM_BITS-1:0];
      end else begin
        col_d = col_inc[DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  // pixel and its raster position, captured together
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= s_axis_tdata;
      pcol_q <= col_q;
      prow_q <= row_q;
    end
  end

  assign pix_valid_o = in_valid_q;
  assign pix_o       = pix_q;
  assign col_o       = pcol_q;
  assign row_o       = prow_q;

endmodule

/* src/cck_map.sv */
// Screen placement, clipping, color key and address math, with the result register.
// Depends on cck_pkg for widths and pack_colour.
module cck_map #(
  parameter int unsigned DIM_BITS = 13
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [cck_pkg::ADDR_W-1:0]                  frame_base_i,
  input  logic [DIM_BITS-1:0]                         screen_width_i,
  input  logic [DIM_BITS-1:0]                         screen_height_i,
  input  logic [DIM_BITS-1:0]                         line_pitch_i,
  input  logic                                        byte_order_i,
  input  logic [DIM_BITS-1:0]                         image_width_i,
  input  logic [DIM_BITS-1:0]                         image_height_i,
  input  logic                                        pix_valid_i,
  input  logic [cck_pkg::PIX_W-1:0]                   pix_i,
  input  logic [DIM_BITS-1:0]                         col_i,
  input  logic [DIM_BITS-1:0]                         row_i,
  output logic                                        stage_en_o,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [cck_pkg::ADDR_W+cck_pkg::COLOR_W-1:0] m_axis_tdata
);

  localparam int unsigned SW  = DIM_BITS + 2;      // signed position width
  localparam int unsigned IDW = 2 * DIM_BITS + 1;  // pixel index width

  logic signed [SW-1:0] xdiff, ydiff, x0, y0, dx, dy;
  logic                 dx_ok, dy_ok, emit;
  logic [2*DIM_BITS-1:0] prod;
  logic [IDW-1:0]        idx;
  logic [cck_pkg::ADDR_W-1:0]  addr;
  logic                        out_valid_q, out_valid_d;
  logic [cck_pkg::ADDR_W-1:0]  addr_q;
  logic [cck_pkg::COLOR_W-1:0] data_q;

  assign xdiff = $signed({2'b00, screen_width_i}) - $signed({2'b00, image_width_i});
  assign ydiff = $signed({2'b00, screen_height_i}) - $signed({2'b00, image_height_i});
  // halve, rounding toward zero
  assign x0 = (xdiff + $signed(SW'(xdiff[SW-1]))) >>> 1;
  assign y0 = (ydiff + $signed(SW'(ydiff[SW-1]))) >>> 1;
  assign dx = x0 + $signed({2'b00, col_i});
  assign dy = y0 + $signed({2'b00, row_i});

  assign dx_ok = !dx[SW-1] && (dx[SW-2:0] < {1'b0, screen_width_i});
  assign dy_ok = !dy[SW-1] && (dy[SW-2:0] < {1'b0, screen_height_i});

  assign emit = (frame_base_i != '0) && (screen_width_i != '0) && (screen_height_i != '0)
             && (col_i < image_width_i) && (row_i < image_height_i)
             && (pix_i != '0) && dx_ok && dy_ok;

  assign prod = dy[DIM_BITS-1:0] * line_pitch_i;
  assign idx  = {1'b0, prod} + IDW'(dx[DIM_BITS-1:0]);
  assign addr = frame_base_i + cck_pkg::ADDR_W'({idx, 2'b00});

  assign stage_en_o  = !out_valid_q || m_axis_tready;
  assign out_valid_d = stage_en_o ? (pix_valid_i && emit) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_o && pix_valid_i && emit) begin
      addr_q <= addr;
      data_q <= cck_pkg::pack_colour(pix_i, byte_order_i);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {data_q, addr_q};

endmodule

/* src/centered_colorkey_blit_top.sv */
// Centered color-key blitter: placement of source pixels into a framebuffer.
// Instantiates cck_regs, cck_raster and cck_map; uses cck_pkg.
//
// Takes one 32-bit source pixel per clock in raster order while the output is not
// stalled; the input register and the result register form a two-stage pipeline
// with a single 13x13 multiply and a 48-bit add between them, and give at most one
// framebuffer write per pixel. The image is centered on the screen, clipped at its
// edges, and all-zero pixels are skipped. The user must write registers over APB
// only while no pixel is in flight; the block itself does not enforce this.
module centered_colorkey_blit_top #(
  parameter int unsigned DIM_BITS = 13
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [cck_pkg::PIX_W-1:0]                   s_axis_tdata,  // [31:0] source_pixel
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // [47:0] write_address, [71:48] write_data
  output logic [cck_pkg::ADDR_W+cck_pkg::COLOR_W-1:0] m_axis_tdata,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [cck_pkg::APB_AW-1:0]                  paddr,
  input  logic [cck_pkg::APB_DW-1:0]                  pwdata,
  output logic [cck_pkg::APB_DW-1:0]                  prdata,
  output logic                                        pready
);

  logic [cck_pkg::ADDR_W-1:0] frame_base;
  logic [DIM_BITS-1:0]        screen_width, screen_height, line_pitch;
  logic [DIM_BITS-1:0]        image_width, image_height;
  logic                       byte_order;
  logic                       stage_en, pix_valid;
  logic [cck_pkg::PIX_W-1:0]  pix;
  logic [DIM_BITS-1:0]        col, row;

  cck_regs #(.DIM_BITS(DIM_BITS)) u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .frame_base_o    (frame_base),
    .screen_width_o  (screen_width),
    .screen_height_o (screen_height),
    .line_pitch_o    (line_pitch),
    .byte_order_o    (byte_order),
    .image_width_o   (image_width),
    .image_height_o  (image_height)
  );

  cck_raster #(.DIM_BITS(DIM_BITS)) u_raster (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .image_width_i  (image_width),
    .image_height_i (image_height),
    .stage_en_i     (stage_en),
    .pix_valid_o    (pix_valid),
    .pix_o          (pix),
    .col_o          (col),
    .row_o          (row)
  );

  cck_map #(.DIM_BITS(DIM_BITS)) u_map (
    .clk_i,
    .rst_ni,
    .frame_base_i    (frame_base),
    .screen_width_i  (screen_width),
    .screen_height_i (screen_height),
    .line_pitch_i    (line_pitch),
    .byte_order_i    (byte_order),
    .image_width_i   (image_width),
    .image_height_i  (image_height),
    .pix_valid_i     (pix_valid),
    .pix_i           (pix),
    .col_i           (col),
    .row_i           (row),
    .stage_en_o      (stage_en),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

endmodule

/* src/cck_checker.sv */
// Port-level checks for the blitter, bound to centered_colorkey_blit_top.
// Depends on cck_pkg for port widths.
module cck_checker (
  input logic                                        clk_i,
  input logic                                        rst_ni,
  input logic                                        s_axis_tvalid,
  input logic                                        s_axis_tready,
  input logic                                        m_axis_tvalid,
  input logic                                        m_axis_tready,
  input logic [cck_pkg::ADDR_W+cck_pkg::COLOR_W-1:0] m_axis_tdata
);

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a new result always stems from a request that passed the input and result registers
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_accept, 2))
    else $error("result without a request");

  // input only backs up behind a stalled result
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with free output");

  // result valid is cleared by the time of the edge after one seen in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind centered_colorkey_blit_top cck_checker u_cck_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* dv/centered_colorkey_blit_top_test.sv */
// Self-checking test for centered_colorkey_blit_top: a directed table and then random frames.
// Each placed pixel is predicted with clipping and color keying, then compared with the write stream.
// Depends on cck_pkg and the block's RTL only.
module centered_colorkey_blit_top_test;
  import cck_pkg::*;

  localparam int unsigned DIM_W         = 13;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned ITEMS_PER_MODE = 330;
  localparam logic [REG_IW-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] data;
  } fb_write_t;

  typedef struct {
    logic [ADDR_W-1:0] base;
    logic [DIM_W-1:0]  sw;
    logic [DIM_W-1:0]  sh;
    logic [DIM_W-1:0]  pitch;
    logic              order;
    logic [DIM_W-1:0]  iw;
    logic [DIM_W-1:0]  ih;
  } blit_cfg_t;

  typedef enum {DIR_CFG, DIR_PIX_PRED, DIR_PIX_NONE, DIR_PIX_WRITE} dir_kind_e;

  typedef struct {
    dir_kind_e          kind;
    logic [REG_IW-1:0]  idx;
    logic [APB_DW-1:0]  value;
    logic [PIX_W-1:0]   px;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] data;
  } dir_step_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [PIX_W-1:0]           s_axis_tdata = '0;   // [31:0] source_pixel
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [ADDR_W+COLOR_W-1:0]  m_axis_tdata;        // [47:0] write_address, [71:48] write_data
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_AW-1:0]          paddr = '0;
  logic [APB_DW-1:0]          pwdata = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  centered_colorkey_blit_top #(.DIM_BITS(DIM_W)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  blit_cfg_t        cfg = '{default: '0};
  logic [DIM_W-1:0] col_count = '0;
  logic [DIM_W-1:0] row_count = '0;
  fb_write_t        pending_writes[$];
  int unsigned      errors = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      rx_hold_req = 0;
  int unsigned      rx_hold_seen = 0;
  int unsigned      rx_hold_left = 0;
  int unsigned      quiet_cycles = 0;

  logic [REG_IW-1:0] reg_list [7] = '{REG_FRAME_BASE, REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT,
                                      REG_LINE_PITCH, REG_BYTE_ORDER, REG_IMAGE_WIDTH,
                                      REG_IMAGE_HEIGHT};

  dir_step_t dir_table [42] = '{
    // reset state: everything suppressed
    '{DIR_PIX_NONE,  REG_UNUSED,        64'h0,            32'hFFFF_FFFF, 48'h0, 24'h0},
    '{DIR_PIX_NONE,  REG_UNUSED,        64'h0,            32'h8000_0001, 48'h0, 24'h0},
    // 4x2 image centered on 8x6 screen, origin (2,2), pitch 16
    '{DIR_CFG,       REG_FRAME_BASE,    64'h1000,         32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_SCREEN_WIDTH,  64'd8,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_SCREEN_HEIGHT, 64'd6,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_LINE_PITCH,    64'd16,           32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_BYTE_ORDER,    64'd0,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_IMAGE_WIDTH,   64'd4,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_IMAGE_HEIGHT,  64'd2,            32'h0, 48'h0, 24'h0},
    '{DIR_PIX_WRITE, REG_UNUSED,        64'h0, 32'h00FF_0000, 48'h1088, 24'h0000FF},
    '{DIR_PIX_NONE,  REG_UNUSED,        64'h0, 32'h0000_0000, 48'h0,    24'h0},
    '{DIR_PIX_WRITE, REG_UNUSED,        64'h0, 32'hFFFF_FFFF, 48'h1090, 24'hFFFFFF},
    '{DIR_PIX_WRITE, REG_UNUSED,        64'h0, 32'h0000_00FF, 48'h1094, 24'hFF0000},
    '{DIR_PIX_WRITE, REG_UNUSED,        64'h0, 32'hFF00_FF00, 48'h10C8, 24'h00FF00},
    // only the unused top byte set: not transparent
    '{DIR_PIX_WRITE, REG_UNUSED,        64'h0, 32'hFF00_0000, 48'h10CC, 24'h000000},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h0012_3456, 48'h0,    24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h7FAB_CDEF, 48'h0,    24'h0},
    // image larger than screen: negative odd offsets, clipping
    '{DIR_CFG,       REG_BYTE_ORDER,    64'd1,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_SCREEN_WIDTH,  64'd4,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_SCREEN_HEIGHT, 64'd3,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_IMAGE_WIDTH,   64'd7,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_IMAGE_HEIGHT,  64'd5,            32'h0, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h00A1_B2C3, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h0102_0304, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h55AA_55AA, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'hAA55_AA55, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h00FF_FFFF, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h1234_5678, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h89AB_CDEF, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h0F0F_0F0F, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'hF0F0_F0F0, 48'h0, 24'h0},
    // extremes; shrinking the image leaves the counters outside it
    '{DIR_CFG,       REG_FRAME_BASE,    64'hFFFF_FFFF_FFFC, 32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_SCREEN_WIDTH,  64'd8191,         32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_SCREEN_HEIGHT, 64'd8191,         32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_LINE_PITCH,    64'd8191,         32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_IMAGE_WIDTH,   64'd1,            32'h0, 48'h0, 24'h0},
    '{DIR_CFG,       REG_IMAGE_HEIGHT,  64'd1,            32'h0, 48'h0, 24'h0},
    '{DIR_PIX_PRED,  REG_UNUSED,        64'h0, 32'h00FE_DCBA, 48'h0, 24'h0},
    // address wraps past 48 bits
    '{DIR_PIX_WRITE, REG_UNUSED,        64'h0, 32'hFFFF_FFFF, 48'h0000_07FF_7FFC, 24'hFFFFFF},
    '{DIR_CFG,       REG_UNUSED,        64'h1234,         32'h0, 48'h0, 24'h0},
    // empty image
    '{DIR_CFG,       REG_IMAGE_WIDTH,   64'd0,            32'h0, 48'h0, 24'h0},
    '{DIR_PIX_NONE,  REG_UNUSED,        64'h0, 32'h00FF_FFFF, 48'h0, 24'h0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic void apply_reg(logic [REG_IW-1:0] idx, logic [APB_DW-1:0] value);
    case (idx)
      REG_FRAME_BASE:    cfg.base  = value[ADDR_W-1:0];
      REG_SCREEN_WIDTH:  cfg.sw    = value[DIM_W-1:0];
      REG_SCREEN_HEIGHT: cfg.sh    = value[DIM_W-1:0];
      REG_LINE_PITCH:    cfg.pitch = value[DIM_W-1:0];
      REG_BYTE_ORDER:    cfg.order = value[0];
      REG_IMAGE_WIDTH:   cfg.iw    = value[DIM_W-1:0];
      REG_IMAGE_HEIGHT:  cfg.ih    = value[DIM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [APB_DW-1:0] reg_value(logic [REG_IW-1:0] idx);
    case (idx)
      REG_FRAME_BASE:    return APB_DW'(cfg.base);
      REG_SCREEN_WIDTH:  return APB_DW'(cfg.sw);
      REG_SCREEN_HEIGHT: return APB_DW'(cfg.sh);
      REG_LINE_PITCH:    return APB_DW'(cfg.pitch);
      REG_BYTE_ORDER:    return APB_DW'(cfg.order);
      REG_IMAGE_WIDTH:   return APB_DW'(cfg.iw);
      REG_IMAGE_HEIGHT:  return APB_DW'(cfg.ih);
      default:           return '0;
    endcase
  endfunction

  // screen placement of the pixel at the current raster position, then counter advance
  function automatic void place_pixel(input logic [PIX_W-1:0] px, output bit hit,
                                      output fb_write_t w);
    int          x0;
    int          y0;
    int          dx;
    int          dy;
    logic [63:0] idx;
    logic [63:0] sum;
    hit = 1'b1;
    w = '{default: '0};
    if (cfg.base == '0 || cfg.sw == '0 || cfg.sh == '0) hit = 1'b0;
    if (cfg.iw == '0 || cfg.ih == '0) hit = 1'b0;
    if (col_count >= cfg.iw || row_count >= cfg.ih) hit = 1'b0;
    if (px == '0) hit = 1'b0;
    // signed division truncates toward zero
    x0 = (int'(cfg.sw) - int'(cfg.iw)) / 2;
    y0 = (int'(cfg.sh) - int'(cfg.ih)) / 2;
    dx = x0 + int'(col_count);
    dy = y0 + int'(row_count);
    if (dx < 0 || dx >= int'(cfg.sw)) hit = 1'b0;
    if (dy < 0 || dy >= int'(cfg.sh)) hit = 1'b0;
    if (hit) begin
      idx = 64'(dy) * 64'(cfg.pitch) + 64'(dx);
      sum = 64'(cfg.base) + (idx << 2);
      w.addr = sum[ADDR_W-1:0];
      w.data = (cfg.order == ORDER_BGR) ? {px[23:16], px[15:8], px[7:0]}
                                        : {px[7:0], px[15:8], px[23:16]};
    end
    if (cfg.iw == '0 || cfg.ih == '0) begin
      col_count = '0;
      row_count = '0;
    end else if (int'(col_count) + 1 >= int'(cfg.iw)) begin
      col_count = '0;
      row_count = (int'(row_count) + 1 >= int'(cfg.ih)) ? '0 : row_count + 1'b1;
    end else begin
      col_count = col_count + 1'b1;
    end
  endfunction

  // called and returns just after a falling edge; valid stays up for the next pixel
  task automatic send_pixel(input logic [PIX_W-1:0] px, input dir_kind_e kind,
                            input fb_write_t typed);
    bit        hit;
    fb_write_t w;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = px;
    do @(posedge clk_i); while (!s_axis_tready);
    place_pixel(px, hit, w);
    case (kind)
      DIR_PIX_NONE:  ;
      DIR_PIX_WRITE: pending_writes.push_back(typed);
      default:       if (hit) pending_writes.push_back(w);
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain_writes();
    s_axis_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [REG_IW-1:0] idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] rd;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    apply_reg(idx, value);
    if (idx != REG_UNUSED) begin
      psel   = 1'b1;
      pwrite = 1'b0;
      @(negedge clk_i);
      penable = 1'b1;
      @(posedge clk_i);
      rd = prdata;
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
      if (rd !== reg_value(idx))
        flag_error($sformatf("register %0d readback: expected %h, got %h",
                             idx, reg_value(idx), rd));
    end
  endtask

  // set upper bits beyond the register width now and then; they must be dropped
  function automatic logic [APB_DW-1:0] with_junk(logic [APB_DW-1:0] v, int unsigned w);
    logic [APB_DW-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(3) == 0) return v | (junk & ~((64'd1 << w) - 64'd1));
    return v;
  endfunction

  function automatic logic [APB_DW-1:0] pick_dim(int unsigned hi);
    case ($urandom_range(9))
      0:       return 64'd0;
      1:       return 64'd8191;
      default: return APB_DW'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic random_setup(input bit all_regs);
    logic [APB_DW-1:0] v;
    for (int i = 0; i < 7; i++) begin
      if (all_regs || $urandom_range(3) != 0) begin
        case (reg_list[i])
          REG_FRAME_BASE: begin
            case ($urandom_range(11))
              0:       v = 64'd0;
              1:       v = 64'hFFFF_FFFF_FFFF;
              default: v = {16'h0, 16'($urandom), $urandom};
            endcase
            v = with_junk(v, ADDR_W);
          end
          REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT: v = with_junk(pick_dim(24), DIM_W);
          REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT:   v = with_junk(pick_dim(12), DIM_W);
          REG_LINE_PITCH:                      v = with_junk(pick_dim(8191), DIM_W);
          default:                             v = with_junk(APB_DW'($urandom_range(1)), 1);
        endcase
        apb_write(reg_list[i], v);
      end
    end
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    fb_write_t got;
    fb_write_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.addr = m_axis_tdata[ADDR_W-1:0];
      got.data = m_axis_tdata[ADDR_W+COLOR_W-1:ADDR_W];
      if (pending_writes.size() == 0) begin
        flag_error($sformatf("unexpected write: addr %h data %h", got.addr, got.data));
      end else begin
        want = pending_writes.pop_front();
        if (got.addr !== want.addr)
          flag_error($sformatf("write address: expected %h, got %h", want.addr, got.addr));
        if (got.data !== want.data)
          flag_error($sformatf("write data: expected %h, got %h", want.data, got.data));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
    begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned frame;
    int unsigned n;
    int unsigned sent;
    bit          first;
    fb_write_t   typed;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin tx_idle_pct = 17; rx_idle_pct = 78; end
        1:       begin tx_idle_pct = 78; rx_idle_pct = 17; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase

      if (mode == 0) begin
        foreach (dir_table[i]) begin
          if (dir_table[i].kind == DIR_CFG) begin
            drain_writes();
            apb_write(dir_table[i].idx, dir_table[i].value);
          end else begin
            typed.addr = dir_table[i].addr;
            typed.data = dir_table[i].data;
            send_pixel(dir_table[i].px, dir_table[i].kind, typed);
          end
        end
      end

      if (mode == 2) begin
        // fill the pipe against a stalled receiver, pause until all writes are out, then send more
        drain_writes();
        apb_write(REG_FRAME_BASE, 64'h40);
        apb_write(REG_SCREEN_WIDTH, 64'd16);
        apb_write(REG_SCREEN_HEIGHT, 64'd16);
        apb_write(REG_LINE_PITCH, 64'd16);
        apb_write(REG_IMAGE_WIDTH, 64'd8);
        apb_write(REG_IMAGE_HEIGHT, 64'd8);
        rx_hold_req++;
        for (int k = 0; k < 24; k++) send_pixel($urandom | 32'h1, DIR_PIX_PRED, '{default: '0});
        s_axis_tvalid = 1'b0;
        while (pending_writes.size() != 0) @(negedge clk_i);
        for (int k = 0; k < 24; k++) send_pixel($urandom | 32'h1, DIR_PIX_PRED, '{default: '0});
      end

      first = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_MODE) begin
        drain_writes();
        random_setup(first);
        first = 1'b0;
        // mostly whole small frames, so every image position gets visited
        frame = int'(cfg.iw) * int'(cfg.ih);
        if (frame > 0 && frame <= 60) n = frame + $urandom_range(0, frame);
        else n = $urandom_range(6, 40);
        for (int k = 0; k < n; k++)
          send_pixel(($urandom_range(7) == 0) ? '0 : $urandom, DIR_PIX_PRED, '{default: '0});
        sent += n;
      end
    end

    drain_writes();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/cck_pkg.sv
src/cck_regs.sv
src/cck_raster.sv
src/cck_map.sv
src/centered_colorkey_blit_top.sv
src/cck_checker.sv
dv/centered_colorkey_blit_top_test.sv
